/* src/selu_pkg.sv */
// ----------------------------------------------------------------------------
// selu_pkg
// Shared constants, types and tables for the SELU activation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package selu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COEF_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EXP_W     = 17;
  localparam int unsigned EXP_TERMS = 10;
  // exp unit: three reduction stages, three per series term, one output stage
  localparam int unsigned EXP_LAT   = 3 + 3 * EXP_TERMS + 1;

  localparam logic [COEF_W-1:0] ALPHA_RST  = 20'd109659;
  localparam logic [COEF_W-1:0] LAMBDA_RST = 20'd68859;

  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [30:0] Q30_ONE  = 31'd1073741824;
  localparam logic [8:0]  INV_LN2  = 9'd369;          // floor(2^38 / LN2_Q30)
  localparam logic [31:0] U_LIMIT  = 32'd1048576;     // 16.0 in Q16.16

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 2'd0,
    REG_LAMBDA = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic        z;
    logic [4:0]  k;
    logic [29:0] r;
  } exp_ctl_t;

  // floor(2^33 / j) for the series divisors
  function automatic logic [33:0] recip(input logic [3:0] j);
    logic [33:0] m;
    case (j)
      4'd1:    m = 34'd8589934592;
      4'd2:    m = 34'd4294967296;
      4'd3:    m = 34'd2863311530;
      4'd4:    m = 34'd2147483648;
      4'd5:    m = 34'd1717986918;
      4'd6:    m = 34'd1431655765;
      4'd7:    m = 34'd1227133513;
      4'd8:    m = 34'd1073741824;
      4'd9:    m = 34'd954437176;
      4'd10:   m = 34'd858993459;
      default: m = 34'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* src/selu_exp.sv */
// ----------------------------------------------------------------------------
// selu_exp
// Pipelined exp(-u) in Q16.16: ln2 range reduction, ten-term Horner series.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selu_exp (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [selu_pkg::DATA_W-1:0]   u,
  output logic      [selu_pkg::EXP_W-1:0]    e
);

  logic        s0_z;
  logic [34:0] s0_big;
  logic [4:0]  s0_q;
  logic        s1_z;
  logic [4:0]  s1_q;
  logic [30:0] s1_r;

  logic [29:0] s0_prod_q;
  logic [34:0] s1_r_next;

  selu_pkg::exp_ctl_t a_st [0:selu_pkg::EXP_TERMS-1];
  selu_pkg::exp_ctl_t b_st [0:selu_pkg::EXP_TERMS-1];
  selu_pkg::exp_ctl_t c_st [0:selu_pkg::EXP_TERMS];
  logic [60:0] a_prod [0:selu_pkg::EXP_TERMS-1];
  logic [30:0] b_t    [0:selu_pkg::EXP_TERMS-1];
  logic [30:0] b_q    [0:selu_pkg::EXP_TERMS-1];
  logic [30:0] c_p    [0:selu_pkg::EXP_TERMS];

  assign s0_prod_q = 30'(u[20:0]) * 30'(selu_pkg::INV_LN2);
  assign s1_r_next = s0_big - 35'(s0_q) * 35'(selu_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_z   <= (u > selu_pkg::U_LIMIT);
      s0_big <= {u[20:0], 14'd0};
      s0_q   <= s0_prod_q[28:24];
      s1_z   <= s0_z;
      s1_q   <= s0_q;
      s1_r   <= s1_r_next[30:0];
      c_st[0].z <= s1_z;
      c_p[0]    <= selu_pkg::Q30_ONE;
      if (s1_r >= 31'(selu_pkg::LN2_Q30)) begin
        c_st[0].k <= s1_q + 5'd1;
        c_st[0].r <= 30'(s1_r - 31'(selu_pkg::LN2_Q30));
      end else begin
        c_st[0].k <= s1_q;
        c_st[0].r <= s1_r[29:0];
      end
    end
  end

  for (genvar g = 0; g < selu_pkg::EXP_TERMS; g++) begin : g_term
    localparam logic [3:0] J = 4'(selu_pkg::EXP_TERMS - g);
    logic [30:0] t_next;
    logic [64:0] q_prod;
    logic [34:0] rem;
    logic [30:0] q_fix;

    assign t_next = 31'((a_prod[g] + 61'(1 << 29)) >> 30);
    assign q_prod = 65'(t_next) * 65'(selu_pkg::recip(J));
    assign rem    = 35'(b_t[g]) - 35'(b_q[g]) * 35'(J);
    assign q_fix  = (rem >= 35'(J)) ? b_q[g] + 31'd1 : b_q[g];

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod[g]  <= 61'(c_st[g].r) * 61'(c_p[g]);
        a_st[g]    <= c_st[g];
        b_t[g]     <= t_next;
        b_q[g]     <= q_prod[63:33];
        b_st[g]    <= a_st[g];
        c_p[g+1]   <= selu_pkg::Q30_ONE - q_fix;
        c_st[g+1]  <= b_st[g];
      end
    end
  end

  logic [5:0]  sh;
  logic [37:0] wide;

  assign sh   = 6'(c_st[selu_pkg::EXP_TERMS].k) + 6'd14;
  assign wide = 38'(c_p[selu_pkg::EXP_TERMS]) + (38'd1 << (sh - 6'd1));

  always_ff @(posedge clk) begin
    if (en) begin
      e <= c_st[selu_pkg::EXP_TERMS].z ? '0 : 17'(wide >> sh);
    end
  end

endmodule

`default_nettype wire

/* src/selu_activation_unit.sv */
// ----------------------------------------------------------------------------
// selu_activation_unit
// Element-wise SELU forward activation and gradient in signed Q16.16.
//
// Input channel (in_valid/in_ready) carries action, value, grad and last;
// output channel (out_valid/out_ready) carries result and last_out. One word
// in gives one word out, in order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// alpha (index 0) or lambda (index 1); other indexes are dropped. Write only
// while no word is in flight.
// The exp pipeline (range reduction plus three stages per series term) is
// followed by operand, multiply and round/saturate stages. Throughput is one
// word per cycle while not stalled; the final stage is the output register.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and restores the default alpha and lambda.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selu_activation_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             action,
  input  wire logic signed [selu_pkg::DATA_W-1:0] value,
  input  wire logic signed [selu_pkg::DATA_W-1:0] grad,
  input  wire logic                             last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [selu_pkg::DATA_W-1:0]    result,
  output logic                                  last_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [selu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [selu_pkg::COEF_W-1:0]      cfg_data
);

  localparam int unsigned LAT = selu_pkg::EXP_LAT;

  typedef struct packed {
    logic               action;
    logic               neg;
    logic signed [31:0] value;
    logic signed [31:0] grad;
    logic               last;
  } side_t;

  typedef struct packed {
    logic               action;
    logic               neg;
    logic               last;
    logic signed [32:0] a_op;
    logic signed [31:0] b_op;
    logic [16:0]        e;
  } opnd_t;

  typedef struct packed {
    logic               action;
    logic               neg;
    logic               last;
    logic signed [64:0] plin;
    logic [56:0]        pexp;
  } prod_t;

  logic [selu_pkg::COEF_W-1:0] alpha;
  logic [selu_pkg::COEF_W-1:0] lambda;
  logic [39:0]                 la;
  logic [24:0]                 c;
  logic                        en;

  side_t side [0:LAT-1];
  logic  vld  [0:LAT-1];
  opnd_t f1;
  prod_t f2;
  logic  f1_vld;
  logic  f2_vld;
  logic  [16:0] e;
  logic  [31:0] u;

  assign en        = ~out_valid | out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign u         = 32'(-value);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= selu_pkg::ALPHA_RST;
      lambda <= selu_pkg::LAMBDA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        selu_pkg::REG_ALPHA:  alpha  <= cfg_data;
        selu_pkg::REG_LAMBDA: lambda <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    la <= 40'(alpha) * 40'(lambda);
    c  <= 25'((la + 40'd32768) >> 16);
  end

  selu_exp u_exp (
    .clk (clk),
    .en  (en),
    .u   (u),
    .e   (e)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
      f1_vld    <= 1'b0;
      f2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
      f1_vld    <= vld[LAT-1];
      f2_vld    <= f1_vld;
      out_valid <= f2_vld;
    end
  end

  logic signed [64:0] f3_mag_src;
  logic [64:0]        f3_mag;
  logic [49:0]        f3_rnd;
  logic [31:0]        lin_res;
  logic [24:0]        exp_mag;

  assign f3_mag  = f2.plin[64] ? 65'(-f2.plin) : 65'(f2.plin);
  assign f3_mag_src = f2.plin;
  assign f3_rnd  = 50'((66'(f3_mag) + 66'd32768) >> 16);
  assign exp_mag = 25'((58'(f2.pexp) + 58'h80000000) >> 32);

  always_comb begin
    if (f3_mag_src[64]) begin
      lin_res = (f3_rnd > 50'h80000000) ? 32'h80000000 : 32'(-f3_rnd);
    end else begin
      lin_res = (f3_rnd > 50'h7FFFFFFF) ? 32'h7FFFFFFF : f3_rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].action <= action;
      side[0].neg    <= value[31] | (value == '0);
      side[0].value  <= value;
      side[0].grad   <= grad;
      side[0].last   <= last;
      for (int i = 1; i < LAT; i++) side[i] <= side[i-1];

      f1.action <= side[LAT-1].action;
      f1.neg    <= side[LAT-1].neg;
      f1.last   <= side[LAT-1].last;
      f1.e      <= e;
      f1.b_op   <= side[LAT-1].action ? side[LAT-1].grad : side[LAT-1].value;
      if (side[LAT-1].action && side[LAT-1].neg) begin
        f1.a_op <= {side[LAT-1].value[31], side[LAT-1].value} + $signed({8'd0, c});
      end else begin
        f1.a_op <= $signed({13'd0, lambda});
      end

      f2.action <= f1.action;
      f2.neg    <= f1.neg;
      f2.last   <= f1.last;
      f2.plin   <= 65'(f1.a_op) * 65'(f1.b_op);
      f2.pexp   <= 57'(la) * 57'(17'd65536 - f1.e);

      result   <= (~f2.action & f2.neg) ? 32'(-$signed({7'd0, exp_mag})) : lin_res;
      last_out <= f2.last;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word missing from first stage");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-1] |-> (e <= 17'd65536))
    else $error("exp out of range");

  a_fwd_neg_sign: assert property (@(posedge clk) disable iff (rst)
    (f2_vld && en && !f2.action && f2.neg) |=> (result[31] || result == '0))
    else $error("negative-branch activation positive");

endmodule

`default_nettype wire
